// File: sv/serial_command_frame_parser_assert.svh
// Assertion macros shared by the checker of the serial command frame parser.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef SERIAL_COMMAND_FRAME_PARSER_ASSERT_SVH
`define SERIAL_COMMAND_FRAME_PARSER_ASSERT_SVH

// Check a property at every rising clock edge outside reset
`define SCFP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition implies another one in the next cycle
`define SCFP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   `SCFP_ASSERT(lbl, clk, rst, (ante) |=> (cons), msg)

`endif

// File: sv/scfp_pkg.sv
// Shared types and constants of the serial command frame parser.
// Depends on nothing; imported by the top level, the decoder and the checker.
package scfp_pkg;

   // Header and command bytes
   localparam logic [7:0] HDR_FIRST  = 8'hA5;
   localparam logic [7:0] HDR_SECOND = 8'h5A;
   localparam logic [7:0] CMD_GAIN   = 8'h02;
   localparam logic [7:0] CMD_TARGET = 8'h03;

   // Gain selectors carried in byte 4
   localparam logic [7:0] GAIN_SEL_P = 8'h00;
   localparam logic [7:0] GAIN_SEL_I = 8'h01;
   localparam logic [7:0] GAIN_SEL_D = 8'h02;

   // Response action codes
   localparam logic [2:0] ACT_NONE   = 3'd0;
   localparam logic [2:0] ACT_TARGET = 3'd1;
   localparam logic [2:0] ACT_GAIN_P = 3'd2;
   localparam logic [2:0] ACT_GAIN_I = 3'd3;
   localparam logic [2:0] ACT_GAIN_D = 3'd4;

   // First and last frame byte read by the decoder
   localparam int VIEW_FIRST = 3;
   localparam int VIEW_LAST  = 8;

   // Frame bytes 3..8, element 0 is byte 3
   typedef logic [VIEW_LAST-VIEW_FIRST:0][7:0] view_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [31:0] value;
   } result_type;

endpackage

// File: sv/serial_command_frame_parser.sv
// Top level of the serial command frame parser: header hunt, byte cell chain, response register.
// Depends on scfp_pkg, scfp_cell and scfp_decode.
//
//   channel  dir  tdata (low bit up)        tuser
//   req_     in   rx_byte[7:0]              -
//   rsp_     out  value[31:0]               action[2:0]
//
// One byte is taken per cycle while req_tready is high; a response appears the cycle after the last frame byte.
// Bytes move one cell along the chain on each accepted request, so the decoder sees
// frame bytes 3..8 from fixed cells when the last frame byte arrives.
// Synchronous reset clears the hunt state and the response valid; cells hold no reset.
// req_tready drops only while the last frame byte is due and a response is stalled.
module serial_command_frame_parser #(
   parameter int FRAME_LENGTH = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte[7:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // value[31:0]
   output logic [2:0]  rsp_tuser    // action[2:0]
);
   import scfp_pkg::*;

   localparam int NUM_CELLS   = FRAME_LENGTH - 4;
   localparam int COUNT_WIDTH = $clog2(FRAME_LENGTH);

   localparam logic [1:0] PH_HUNT = 2'd0;
   localparam logic [1:0] PH_HEAD = 2'd1;
   localparam logic [1:0] PH_BODY = 2'd2;

   logic [1:0]             phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   result_type             rsp_ff, rsp_in;

   logic                   accept;
   logic                   last_byte;
   logic [NUM_CELLS-1:0][7:0] cell_q;
   view_type               view;

   assign last_byte  = (phase_ff == PH_BODY) &&
                       (count_ff == COUNT_WIDTH'(FRAME_LENGTH - 1));
   assign req_tready = !(last_byte && rsp_valid_ff && !rsp_tready);
   assign accept     = req_tvalid && req_tready;

   // chain of byte cells, cell 0 takes the incoming byte
   for (genvar j = 0; j < NUM_CELLS; j++) begin : g_cell
      if (j == 0) begin : g_head
         scfp_cell u_cell (
            .clock    (clock),
            .shift    (accept),
            .data_in  (req_tdata),
            .data_out (cell_q[j])
         );
      end else begin : g_tail
         scfp_cell u_cell (
            .clock    (clock),
            .shift    (accept),
            .data_in  (cell_q[j-1]),
            .data_out (cell_q[j])
         );
      end
   end

   // map frame bytes 3..8 onto the chain; the last frame byte is still at the input
   for (genvar k = VIEW_FIRST; k <= VIEW_LAST; k++) begin : g_view
      if (k == FRAME_LENGTH - 1) begin : g_live
         assign view[k - VIEW_FIRST] = req_tdata;
      end else begin : g_held
         assign view[k - VIEW_FIRST] = cell_q[FRAME_LENGTH - 2 - k];
      end
   end

   scfp_decode u_decode (
      .view   (view),
      .result (rsp_in)
   );

   // advance the header hunt and frame count
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_HEAD: begin
               if (req_tdata == HDR_SECOND) begin
                  phase_in = PH_BODY;
                  count_in = COUNT_WIDTH'(2);
               end else begin
                  phase_in = PH_HUNT;
                  count_in = '0;
               end
            end
            PH_BODY: begin
               if (last_byte) begin
                  phase_in = PH_HUNT;
                  count_in = '0;
               end else begin
                  count_in = count_ff + COUNT_WIDTH'(1);
               end
            end
            default: begin
               phase_in = PH_HUNT;
               if (req_tdata == HDR_FIRST) begin
                  phase_in = PH_HEAD;
                  count_in = COUNT_WIDTH'(1);
               end
            end
         endcase
      end
   end

   // hold the response until it is taken
   always_comb begin
      if (accept && last_byte) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && last_byte) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff.value;
   assign rsp_tuser  = rsp_ff.action;

endmodule

// File: sv/scfp_cell.sv
// One byte cell of the frame shift chain.
// Depends on nothing; instantiated in a row by serial_command_frame_parser.
module scfp_cell (
   input  logic       clock,
   input  logic       shift,
   input  logic [7:0] data_in,
   output logic [7:0] data_out
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   // take the neighbour's byte on every accepted request
   assign byte_in  = shift ? data_in : byte_ff;
   assign data_out = byte_ff;

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

endmodule

// File: sv/scfp_decode.sv
// Frame decoder: turns frame bytes 3..8 into an action and a value.
// Depends on scfp_pkg.
module scfp_decode (
   input  scfp_pkg::view_type   view,
   output scfp_pkg::result_type result
);
   import scfp_pkg::*;

   logic [7:0] cmd;
   logic [7:0] sel;

   assign cmd = view[3 - VIEW_FIRST];
   assign sel = view[4 - VIEW_FIRST];

   // target first, then a gain with a known selector, else nothing
   always_comb begin
      result.action = ACT_NONE;
      result.value  = 32'd0;
      priority if (cmd == CMD_TARGET) begin
         result.action = ACT_TARGET;
         result.value  = {16'd0, view[8 - VIEW_FIRST], view[7 - VIEW_FIRST]};
      end else if (cmd == CMD_GAIN && (sel == GAIN_SEL_P || sel == GAIN_SEL_I ||
                                       sel == GAIN_SEL_D)) begin
         result.action = ACT_GAIN_P + {1'b0, sel[1:0]};
         result.value  = {view[8 - VIEW_FIRST], view[7 - VIEW_FIRST],
                          view[6 - VIEW_FIRST], view[5 - VIEW_FIRST]};
      end else begin
         result.action = ACT_NONE;
      end
   end

endmodule

// File: sv/scfp_checker.sv
// Port checker of the serial command frame parser, bound to the top level.
// Depends on scfp_pkg and serial_command_frame_parser_assert.svh.
`include "serial_command_frame_parser_assert.svh"

module scfp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);
   import scfp_pkg::*;

   // a stalled response keeps its payload
   `SCFP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled response changed")

   // a new response follows an accepted request
   `SCFP_ASSERT(a_rsp_cause, clock, reset, $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready), "response without request")

   // action codes stay in range
   `SCFP_ASSERT(a_action_range, clock, reset, rsp_tvalid |-> (rsp_tuser == ACT_NONE || rsp_tuser == ACT_TARGET || rsp_tuser == ACT_GAIN_P || rsp_tuser == ACT_GAIN_I || rsp_tuser == ACT_GAIN_D), "bad action code")

   // a target carries 16 bits, no action carries zero
   `SCFP_ASSERT(a_target_width, clock, reset, rsp_tvalid && rsp_tuser == ACT_TARGET |-> rsp_tdata[31:16] == 16'd0, "target upper bits set")
   `SCFP_ASSERT(a_none_zero, clock, reset, rsp_tvalid && rsp_tuser == ACT_NONE |-> rsp_tdata == 32'd0, "empty action with value")

endmodule

bind serial_command_frame_parser scfp_checker u_scfp_checker (.*);
